/* rtl/core/mxrse_pkg.sv */
`timescale 1ns / 1ps

package mxrse_pkg;

  localparam int DATA_W          = 64;
  localparam int CNT_W           = 32;
  localparam int REG_IDX_W       = 4;
  localparam int TOP_W           = 11;
  localparam int WORD_BYTES      = 8;
  localparam int SLOT_LSB        = $clog2(WORD_BYTES);
  localparam int STACK_WORDS     = 256;
  localparam int SLOT_W          = $clog2(STACK_WORDS);
  localparam int EA_W            = SLOT_LSB + SLOT_W;
  localparam int REGISTERS_DEF   = 16;
  localparam int SP_INDEX_DEF    = 4;
  localparam int STACK_TOP_RESET = 2040;
  localparam int IN_W            = 160;
  localparam int OUT_W           = 168;

  typedef enum logic [2:0] {
    CMD_INC  = 3'd0,
    CMD_DEC  = 3'd1,
    CMD_ADD  = 3'd2,
    CMD_PUSH = 3'd3,
    CMD_POP  = 3'd4,
    CMD_MOVE = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    SRC_REG = 2'd0,
    SRC_IMM = 2'd1,
    SRC_MEM = 2'd2
  } src_e;

  typedef struct packed {
    logic [3:0]           pad;
    logic                 disp_subtract;
    logic [DATA_W-1:0]    displacement;
    logic [3:0]           scale;
    logic                 index_subtract;
    logic [REG_IDX_W-1:0] index_reg;
    logic                 has_index;
    logic [REG_IDX_W-1:0] base_reg;
    logic [DATA_W-1:0]    immediate;
    logic [REG_IDX_W-1:0] src_reg;
    src_e                 src_kind;
    logic [REG_IDX_W-1:0] dest_reg;
    cmd_e                 command;
  } in_t;

  typedef struct packed {
    logic [3:0]           pad;
    logic [CNT_W-1:0]     executed_count;
    logic [DATA_W-1:0]    stack_pointer;
    logic [DATA_W-1:0]    written_value;
    logic [REG_IDX_W-1:0] written_reg;
  } out_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } stk_wr_t;

  typedef struct packed {
    logic              d_we;
    logic              st_we;
    logic [DATA_W-1:0] d_val;
    logic [DATA_W-1:0] sp_val;
    logic [DATA_W-1:0] out_val;
  } alu_res_t;

endpackage

/* rtl/core/mxrse_regfile.sv */
`timescale 1ns / 1ps

module mxrse_regfile #(
  parameter int REGISTERS = mxrse_pkg::REGISTERS_DEF,
  parameter int RW        = $clog2(REGISTERS)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [RW-1:0]               waddr_i,
  input  logic [mxrse_pkg::DATA_W-1:0] wdata_i,
  input  logic                        re_a_i,
  input  logic [RW-1:0]               raddr_a_i,
  output logic [mxrse_pkg::DATA_W-1:0] rdata_a_o,
  input  logic                        re_b_i,
  input  logic [RW-1:0]               raddr_b_i,
  output logic [mxrse_pkg::DATA_W-1:0] rdata_b_o
);

  logic [mxrse_pkg::DATA_W-1:0] mem_q [REGISTERS];
  logic [mxrse_pkg::DATA_W-1:0] rdata_a_q;
  logic [mxrse_pkg::DATA_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* rtl/core/mxrse_stack.sv */
`timescale 1ns / 1ps

module mxrse_stack (
  input  logic                         clk_i,
  input  mxrse_pkg::stk_wr_t           wr_i,
  input  logic                         re_i,
  input  logic [mxrse_pkg::SLOT_W-1:0] raddr_i,
  output logic [mxrse_pkg::DATA_W-1:0] rdata_o
);

  logic [mxrse_pkg::DATA_W-1:0] mem_q [mxrse_pkg::STACK_WORDS];
  logic [mxrse_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/mxrse_alu.sv */
`timescale 1ns / 1ps

module mxrse_alu (
  input  mxrse_pkg::cmd_e              cmd_i,
  input  mxrse_pkg::src_e              kind_i,
  input  logic [mxrse_pkg::DATA_W-1:0] imm_i,
  input  logic [mxrse_pkg::DATA_W-1:0] src_reg_val_i,
  input  logic [mxrse_pkg::DATA_W-1:0] stack_val_i,
  input  logic [mxrse_pkg::DATA_W-1:0] dest_val_i,
  input  logic [mxrse_pkg::DATA_W-1:0] sp_i,
  input  logic                         dest_is_sp_i,
  output mxrse_pkg::alu_res_t          res_o
);

  localparam logic [mxrse_pkg::DATA_W-1:0] WordStep = mxrse_pkg::DATA_W'(mxrse_pkg::WORD_BYTES);

  logic [mxrse_pkg::DATA_W-1:0] src;
  logic [mxrse_pkg::DATA_W-1:0] d_val;
  logic [mxrse_pkg::DATA_W-1:0] sp_mid;
  logic [mxrse_pkg::DATA_W-1:0] sp_val;
  logic                         d_we;
  logic                         is_push;

  always_comb begin
    case (kind_i)
      mxrse_pkg::SRC_REG: src = src_reg_val_i;
      mxrse_pkg::SRC_IMM: src = imm_i;
      mxrse_pkg::SRC_MEM: src = stack_val_i;
      default:            src = '0;
    endcase
  end

  always_comb begin
    d_we  = 1'b0;
    d_val = dest_val_i;
    case (cmd_i)
      mxrse_pkg::CMD_INC: begin
        d_we  = 1'b1;
        d_val = dest_val_i + mxrse_pkg::DATA_W'(1);
      end
      mxrse_pkg::CMD_DEC: begin
        d_we  = 1'b1;
        d_val = dest_val_i - mxrse_pkg::DATA_W'(1);
      end
      mxrse_pkg::CMD_ADD: begin
        d_we  = 1'b1;
        d_val = dest_val_i + src;
      end
      mxrse_pkg::CMD_POP: begin
        d_we  = 1'b1;
        d_val = stack_val_i;
      end
      mxrse_pkg::CMD_MOVE: begin
        d_we  = 1'b1;
        d_val = src;
      end
      default: begin
        d_we  = 1'b0;
        d_val = dest_val_i;
      end
    endcase
  end

  // pop into sp sees the loaded value plus one word
  always_comb begin
    is_push = (cmd_i == mxrse_pkg::CMD_PUSH);
    sp_mid  = (d_we && dest_is_sp_i) ? d_val : sp_i;
    case (cmd_i)
      mxrse_pkg::CMD_PUSH: sp_val = sp_i - WordStep;
      mxrse_pkg::CMD_POP:  sp_val = sp_mid + WordStep;
      default:             sp_val = sp_mid;
    endcase
  end

  always_comb begin
    res_o.d_we    = d_we && !dest_is_sp_i;
    res_o.st_we   = is_push;
    res_o.d_val   = d_val;
    res_o.sp_val  = sp_val;
    res_o.out_val = (is_push || dest_is_sp_i) ? sp_val : d_val;
  end

endmodule

/* rtl/core/mini_x86_register_stack_executor_top.sv */
`timescale 1ns / 1ps
// path: input in x1_q, then stage 2, result in m_data_q; stage 2 holds on a stalled output
// issue: no new instruction is taken while one is in stage 1, because register file port a
//   reads the source or base operand and then the destination of the same word
// reset: all control cleared, stack pointer loaded with 2040, then a clearing pass over all
//   256 stack words zeroes stack memory and register file with s_axis_tready low

module mini_x86_register_stack_executor_top #(
  parameter int REGISTERS           = mxrse_pkg::REGISTERS_DEF,
  parameter int STACK_POINTER_INDEX = mxrse_pkg::SP_INDEX_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // command, dest_reg, src_kind, src_reg, immediate, base_reg, has_index,
  // index_reg, index_subtract, scale, displacement, disp_subtract
  input  logic [mxrse_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // written_reg, written_value, stack_pointer, executed_count
  output logic [mxrse_pkg::OUT_W-1:0]  m_axis_tdata,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mxrse_pkg::TOP_W-1:0]  cfg_data_i
);

  localparam int RW      = $clog2(REGISTERS);
  localparam int SP_SLOT = STACK_POINTER_INDEX % REGISTERS;
  localparam logic [RW-1:0] SpAddr = RW'(SP_SLOT);
  localparam int DW      = mxrse_pkg::DATA_W;
  localparam int SW      = mxrse_pkg::SLOT_W;
  localparam int EW      = mxrse_pkg::EA_W;
  localparam int LSB     = mxrse_pkg::SLOT_LSB;
  localparam logic [SW-1:0] ClrLast = SW'(mxrse_pkg::STACK_WORDS - 1);

  function automatic logic [RW-1:0] reg_slot(input logic [mxrse_pkg::REG_IDX_W-1:0] idx);
    logic [5:0] v;
    v = 6'(idx);
    for (int k = 0; k < 8; k++) begin
      if (v >= 6'(REGISTERS)) begin
        v = v - 6'(REGISTERS);
      end
    end
    return v[RW-1:0];
  endfunction

  mxrse_pkg::in_t      s_in;
  mxrse_pkg::alu_res_t alu_res;
  mxrse_pkg::stk_wr_t  st_wr;
  mxrse_pkg::out_t     out_d;

  logic          acc;
  logic          cfg_acc;
  logic          out_free;
  logic          commit;

  logic          clr_q, clr_d;
  logic [SW-1:0] clr_idx_q, clr_idx_d;
  logic          v1_q, v1_d;
  logic          v2_q, v2_d;
  logic [DW-1:0] sp_q, sp_d;
  logic [mxrse_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic          wb_en_q, wb_en_d;
  logic [RW-1:0] wb_addr_q, wb_addr_d;
  logic [DW-1:0] wb_val_q, wb_val_d;
  logic          m_valid_q, m_valid_d;
  mxrse_pkg::out_t m_data_q, m_data_d;

  mxrse_pkg::in_t  x1_q, x1_d;
  logic [RW-1:0]   a1_q, a1_d;
  logic [RW-1:0]   b1_q, b1_d;
  mxrse_pkg::cmd_e cmd2_q, cmd2_d;
  mxrse_pkg::src_e kind2_q, kind2_d;
  logic [DW-1:0]   imm2_q, imm2_d;
  logic [DW-1:0]   src2_q, src2_d;
  logic [RW-1:0]   d2_q, d2_d;

  logic          rf_we;
  logic [RW-1:0] rf_waddr;
  logic [DW-1:0] rf_wdata;
  logic          rf_re_a;
  logic [RW-1:0] rf_raddr_a;
  logic [DW-1:0] rf_rdata_a;
  logic [DW-1:0] rf_rdata_b;
  logic [RW-1:0] a0;
  logic [RW-1:0] b0;
  logic [RW-1:0] d1;

  logic [DW-1:0] opa;
  logic [DW-1:0] opb;
  logic [EW-1:0] scaled;
  logic [EW-1:0] ea_idx;
  logic [EW-1:0] ea;
  logic [EW-1:0] pop_addr;
  logic [SW-1:0] st_raddr;
  logic [DW-1:0] st_rdata;
  logic [DW-1:0] rd;

  assign s_in        = mxrse_pkg::in_t'(s_axis_tdata);
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_free    = !m_valid_q || m_axis_tready;
  assign commit      = v2_q && out_free;
  assign s_axis_tready = !clr_q && !v1_q && (!v2_q || commit);
  assign acc         = s_axis_tvalid && s_axis_tready;

  // operand reads on accept, destination read in the next cycle
  assign a0 = reg_slot((s_in.src_kind == mxrse_pkg::SRC_MEM) ? s_in.base_reg : s_in.src_reg);
  assign b0 = reg_slot(s_in.index_reg);
  assign d1 = reg_slot(x1_q.dest_reg);
  assign rf_re_a    = acc || v1_q;
  assign rf_raddr_a = v1_q ? d1 : a0;

  always_comb begin
    if (clr_q) begin
      rf_we    = clr_idx_q < SW'(REGISTERS);
      rf_waddr = clr_idx_q[RW-1:0];
      rf_wdata = '0;
    end else begin
      rf_we    = commit && alu_res.d_we;
      rf_waddr = d2_q;
      rf_wdata = alu_res.d_val;
    end
  end

  mxrse_regfile #(
    .REGISTERS (REGISTERS),
    .RW        (RW)
  ) u_regfile (
    .clk_i     (clk_i),
    .we_i      (rf_we),
    .waddr_i   (rf_waddr),
    .wdata_i   (rf_wdata),
    .re_a_i    (rf_re_a),
    .raddr_a_i (rf_raddr_a),
    .rdata_a_o (rf_rdata_a),
    .re_b_i    (acc),
    .raddr_b_i (b0),
    .rdata_b_o (rf_rdata_b)
  );

  // sp lives in a flop; the last write is forwarded over the read it overlapped
  always_comb begin
    if (a1_q == SpAddr) begin
      opa = sp_q;
    end else if (wb_en_q && (wb_addr_q == a1_q)) begin
      opa = wb_val_q;
    end else begin
      opa = rf_rdata_a;
    end
    if (b1_q == SpAddr) begin
      opb = sp_q;
    end else if (wb_en_q && (wb_addr_q == b1_q)) begin
      opb = wb_val_q;
    end else begin
      opb = rf_rdata_b;
    end
  end

  // only the byte offset and word slot bits of the address are formed
  always_comb begin
    scaled   = opb[EW-1:0] * EW'(x1_q.scale);
    if (!x1_q.has_index) begin
      ea_idx = opa[EW-1:0];
    end else if (x1_q.index_subtract) begin
      ea_idx = opa[EW-1:0] - scaled;
    end else begin
      ea_idx = opa[EW-1:0] + scaled;
    end
    ea       = x1_q.disp_subtract ? ea_idx - x1_q.displacement[EW-1:0]
                                  : ea_idx + x1_q.displacement[EW-1:0];
    pop_addr = sp_q[EW-1:0] + EW'(mxrse_pkg::WORD_BYTES);
    st_raddr = (x1_q.command == mxrse_pkg::CMD_POP) ? pop_addr[LSB +: SW] : ea[LSB +: SW];
  end

  always_comb begin
    if (clr_q) begin
      st_wr.we   = 1'b1;
      st_wr.addr = clr_idx_q;
      st_wr.data = '0;
    end else begin
      st_wr.we   = commit && alu_res.st_we;
      st_wr.addr = sp_q[LSB +: SW];
      st_wr.data = rd;
    end
  end

  mxrse_stack u_stack (
    .clk_i   (clk_i),
    .wr_i    (st_wr),
    .re_i    (v1_q),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  assign rd = (d2_q == SpAddr) ? sp_q : rf_rdata_a;

  mxrse_alu u_alu (
    .cmd_i         (cmd2_q),
    .kind_i        (kind2_q),
    .imm_i         (imm2_q),
    .src_reg_val_i (src2_q),
    .stack_val_i   (st_rdata),
    .dest_val_i    (rd),
    .sp_i          (sp_q),
    .dest_is_sp_i  (d2_q == SpAddr),
    .res_o         (alu_res)
  );

  always_comb begin
    out_d.pad            = '0;
    out_d.executed_count = cnt_q + mxrse_pkg::CNT_W'(1);
    out_d.stack_pointer  = alu_res.sp_val;
    out_d.written_value  = alu_res.out_val;
    out_d.written_reg    = (cmd2_q == mxrse_pkg::CMD_PUSH) ? mxrse_pkg::REG_IDX_W'(SP_SLOT)
                                                           : mxrse_pkg::REG_IDX_W'(d2_q);
  end

  always_comb begin
    clr_d     = clr_q && (clr_idx_q != ClrLast);
    clr_idx_d = clr_q ? clr_idx_q + SW'(1) : clr_idx_q;
    v1_d      = acc;
    v2_d      = v1_q || (v2_q && !commit);
    cnt_d     = commit ? cnt_q + mxrse_pkg::CNT_W'(1) : cnt_q;
    if (cfg_acc) begin
      sp_d = DW'(cfg_data_i);
    end else if (commit) begin
      sp_d = alu_res.sp_val;
    end else begin
      sp_d = sp_q;
    end
    wb_en_d   = wb_en_q;
    wb_addr_d = wb_addr_q;
    wb_val_d  = wb_val_q;
    if (commit && alu_res.d_we) begin
      wb_en_d   = 1'b1;
      wb_addr_d = d2_q;
      wb_val_d  = alu_res.d_val;
    end
    m_valid_d = commit || (m_valid_q && !m_axis_tready);
    m_data_d  = commit ? out_d : m_data_q;
  end

  always_comb begin
    x1_d    = acc ? s_in : x1_q;
    a1_d    = acc ? a0 : a1_q;
    b1_d    = acc ? b0 : b1_q;
    cmd2_d  = v1_q ? x1_q.command : cmd2_q;
    kind2_d = v1_q ? x1_q.src_kind : kind2_q;
    imm2_d  = v1_q ? x1_q.immediate : imm2_q;
    src2_d  = v1_q ? opa : src2_q;
    d2_d    = v1_q ? d1 : d2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      sp_q      <= DW'(mxrse_pkg::STACK_TOP_RESET);
      cnt_q     <= '0;
      wb_en_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      clr_q     <= clr_d;
      clr_idx_q <= clr_idx_d;
      v1_q      <= v1_d;
      v2_q      <= v2_d;
      sp_q      <= sp_d;
      cnt_q     <= cnt_d;
      wb_en_q   <= wb_en_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wb_addr_q <= wb_addr_d;
    wb_val_q  <= wb_val_d;
    m_data_q  <= m_data_d;
    x1_q      <= x1_d;
    a1_q      <= a1_d;
    b1_q      <= b1_d;
    cmd2_q    <= cmd2_d;
    kind2_q   <= kind2_d;
    imm2_q    <= imm2_d;
    src2_q    <= src2_d;
    d2_q      <= d2_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

/* rtl/core/mxrse_checker.sv */
`timescale 1ns / 1ps

module mxrse_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [mxrse_pkg::OUT_W-1:0] m_axis_tdata
);

  mxrse_pkg::out_t             m_word;
  logic                        s_acc;
  logic                        m_acc;
  logic [1:0]                  occ_q, occ_d;
  logic [mxrse_pkg::CNT_W-1:0] exp_cnt_q, exp_cnt_d;

  assign m_word = mxrse_pkg::out_t'(m_axis_tdata);
  assign s_acc  = s_axis_tvalid && s_axis_tready;
  assign m_acc  = m_axis_tvalid && m_axis_tready;

  always_comb begin
    occ_d     = occ_q + 2'(s_acc) - 2'(m_acc);
    exp_cnt_d = m_acc ? m_word.executed_count : exp_cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= '0;
      exp_cnt_q <= '0;
    end else begin
      occ_q     <= occ_d;
      exp_cnt_q <= exp_cnt_d;
    end
  end

  // one word in flight plus one parked at the output
  a_occ_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == 2'd2) && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken with two words outstanding");

  a_two_cycle_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("input taken on consecutive cycles");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_acc |-> m_word.executed_count == exp_cnt_q + mxrse_pkg::CNT_W'(1))
    else $error("executed count skipped or repeated");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

endmodule

bind mini_x86_register_stack_executor_top mxrse_checker u_mxrse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* test/mini_x86_register_stack_executor_checker.sv */
`timescale 1ns / 1ps

module mini_x86_register_stack_executor_checker
  import mxrse_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [IN_W-1:0]  in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [OUT_W-1:0] out_data_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [TOP_W-1:0] cfg_data_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o
);

  localparam int SpIdx = SP_INDEX_DEF % REGISTERS_DEF;

  logic [DATA_W-1:0] gpr [REGISTERS_DEF];
  logic [DATA_W-1:0] stack_mem [STACK_WORDS];
  logic [CNT_W-1:0]  exec_count;
  out_t              writeback_q [$];
  int                fails;
  int                checked;

  function automatic logic [DATA_W-1:0] operand_addr(in_t w);
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] scaled;
    addr   = gpr[w.base_reg];
    scaled = gpr[w.index_reg] * DATA_W'(w.scale);
    if (w.has_index) begin
      addr = w.index_subtract ? addr - scaled : addr + scaled;
    end
    addr = w.disp_subtract ? addr - w.displacement : addr + w.displacement;
    return addr;
  endfunction

  function automatic logic [DATA_W-1:0] operand_value(in_t w);
    logic [DATA_W-1:0] addr;
    addr = operand_addr(w);
    case (w.src_kind)
      SRC_REG: return gpr[w.src_reg];
      SRC_IMM: return w.immediate;
      SRC_MEM: return stack_mem[addr[SLOT_LSB +: SLOT_W]];
      default: return '0;
    endcase
  endfunction

  // executes one instruction on the shadow state and returns its write-back word
  function automatic out_t run_instr(in_t w);
    out_t              res;
    logic [REG_IDX_W-1:0] target;
    logic [DATA_W-1:0] operand;
    logic [DATA_W-1:0] pop_addr;
    target = w.dest_reg;
    case (w.command)
      CMD_INC: gpr[target] = gpr[target] + 1;
      CMD_DEC: gpr[target] = gpr[target] - 1;
      CMD_ADD: begin
        operand     = operand_value(w);
        gpr[target] = gpr[target] + operand;
      end
      CMD_PUSH: begin
        stack_mem[gpr[SpIdx][SLOT_LSB +: SLOT_W]] = gpr[target];
        gpr[SpIdx] = gpr[SpIdx] - WORD_BYTES;
        target     = REG_IDX_W'(SpIdx);
      end
      CMD_POP: begin
        pop_addr    = gpr[SpIdx] + WORD_BYTES;
        gpr[target] = stack_mem[pop_addr[SLOT_LSB +: SLOT_W]];
        gpr[SpIdx]  = gpr[SpIdx] + WORD_BYTES;
      end
      CMD_MOVE: gpr[target] = operand_value(w);
      default: ;
    endcase
    exec_count         = exec_count + 1;
    res                = '0;
    res.written_reg    = target;
    res.written_value  = gpr[target];
    res.stack_pointer  = gpr[SpIdx];
    res.executed_count = exec_count;
    return res;
  endfunction

  task automatic compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t got;
    out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < REGISTERS_DEF; i++) begin
        gpr[i] = '0;
      end
      gpr[SpIdx] = DATA_W'(STACK_TOP_RESET);
      for (int i = 0; i < STACK_WORDS; i++) begin
        stack_mem[i] = '0;
      end
      exec_count = '0;
      writeback_q.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = out_t'(out_data_i);
        if (writeback_q.size() == 0) begin
          $display("%0t: result word with no instruction pending, actual %h", $time, got);
          fails++;
        end else begin
          want = writeback_q.pop_front();
          compare_field("written_reg", DATA_W'(want.written_reg), DATA_W'(got.written_reg));
          compare_field("written_value", want.written_value, got.written_value);
          compare_field("stack_pointer", want.stack_pointer, got.stack_pointer);
          compare_field("executed_count", DATA_W'(want.executed_count),
                        DATA_W'(got.executed_count));
          checked++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        gpr[SpIdx] = DATA_W'(cfg_data_i);
      end
      if (in_valid_i && in_ready_i) begin
        writeback_q.push_back(run_instr(in_t'(in_data_i)));
      end
    end
    fail_count_o <= fails;
    pending_o    <= writeback_q.size();
    checked_o    <= checked;
  end

endmodule

/* test/mini_x86_register_stack_executor_top_tb.sv */
`timescale 1ns / 1ps

module mini_x86_register_stack_executor_top_tb;
  import mxrse_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 16;
  localparam int FirstTarget = 200;
  localparam int PhaseItems  = 196;

  logic             clk_i;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [TOP_W-1:0] cfg_data_i    = '0;

  int fail_count;
  int pending;
  int checked;
  int sent       = 0;
  int cfg_writes = 0;
  int cycles     = 0;
  bit steady     = 1'b0;
  bit hold_req   = 1'b0;
  bit hold_done  = 1'b0;

  mini_x86_register_stack_executor_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  mini_x86_register_stack_executor_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_t reg_op(cmd_e c, logic [3:0] d, src_e k, logic [3:0] s,
                                 logic [63:0] imm);
    in_t w;
    w           = '0;
    w.command   = c;
    w.dest_reg  = d;
    w.src_kind  = k;
    w.src_reg   = s;
    w.immediate = imm;
    return w;
  endfunction

  function automatic in_t mem_op(cmd_e c, logic [3:0] d, logic [3:0] base, logic hi,
                                 logic [3:0] idx, logic isub, logic [3:0] scl,
                                 logic [63:0] disp, logic dsub);
    in_t w;
    w                = reg_op(c, d, SRC_MEM, 4'd0, 64'd0);
    w.base_reg       = base;
    w.has_index      = hi;
    w.index_reg      = idx;
    w.index_subtract = isub;
    w.scale          = scl;
    w.displacement   = disp;
    w.disp_subtract  = dsub;
    return w;
  endfunction

  function automatic in_t rand_instr();
    in_t w;
    int  r;
    w     = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    w.pad = '0;
    r = $urandom_range(0, 99);
    w.command = r < 10 ? CMD_INC : r < 20 ? CMD_DEC : r < 38 ? CMD_ADD :
                r < 58 ? CMD_PUSH : r < 75 ? CMD_POP : r < 96 ? CMD_MOVE :
                cmd_e'(3'($urandom_range(6, 7)));
    r = $urandom_range(0, 99);
    w.src_kind = r < 30 ? SRC_REG : r < 60 ? SRC_IMM : r < 97 ? SRC_MEM : src_e'(2'd3);
    r = $urandom_range(0, 7);
    if (r == 0) w.immediate = '0;
    else if (r == 1) w.immediate = '1;
    else if (r == 2) w.immediate = {1'b1, 63'b0};
    else if (r == 3) w.immediate = 64'($urandom_range(0, 255));
    // mostly read back near the top of the stack
    if ($urandom_range(0, 9) < 7) begin
      w.base_reg      = REG_IDX_W'(SP_INDEX_DEF);
      w.has_index     = 1'b0;
      w.displacement  = 64'($urandom_range(0, 6) * WORD_BYTES);
      w.disp_subtract = 1'b0;
    end
    return w;
  endfunction

  task automatic send_instr(in_t w);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_stack_run();
    in_t w;
    int  depth;
    depth = $urandom_range(1, 8);
    repeat (depth) begin
      w         = rand_instr();
      w.command = CMD_PUSH;
      send_instr(w);
    end
    repeat ($urandom_range(0, 4)) send_instr(rand_instr());
    repeat (depth) begin
      w         = rand_instr();
      w.command = CMD_POP;
      send_instr(w);
    end
  endtask

  task automatic send_random(int target);
    while (sent < target) begin
      if ($urandom_range(0, 3) == 0) send_stack_run();
      else send_instr(rand_instr());
    end
  endtask

  task automatic wait_drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_stack_top(logic [TOP_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
  endtask

  // result side
  initial begin : sink
    int gap;
    gap = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        gap = 0;
      end
      if (m_axis_tvalid && m_axis_tready) gap = idle_len();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        gap--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stim
    logic [TOP_W-1:0] tops [6];
    tops[0] = '0;
    tops[1] = '1;
    tops[2] = TOP_W'(8);
    tops[3] = TOP_W'($urandom_range(0, 2047));
    tops[4] = TOP_W'($urandom_range(0, 2047));
    tops[5] = TOP_W'(STACK_TOP_RESET);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_instr(reg_op(CMD_INC, 4'd0, SRC_REG, 4'd0, '0));
    send_instr(reg_op(CMD_DEC, 4'd1, SRC_REG, 4'd0, '0));
    send_instr(reg_op(CMD_INC, 4'd1, SRC_REG, 4'd0, '0));
    send_instr(reg_op(CMD_MOVE, 4'd2, SRC_IMM, 4'd0, '1));
    send_instr(reg_op(CMD_ADD, 4'd2, SRC_IMM, 4'd0, 64'd1));
    send_instr(reg_op(CMD_MOVE, 4'd15, SRC_IMM, 4'd0, 64'h8000_0000_0000_0001));
    send_instr(reg_op(CMD_PUSH, 4'd15, SRC_REG, 4'd0, '0));
    send_instr(reg_op(CMD_PUSH, 4'd0, SRC_REG, 4'd0, '0));
    send_instr(reg_op(CMD_PUSH, 4'd4, SRC_REG, 4'd0, '0));
    send_instr(mem_op(CMD_MOVE, 4'd3, 4'd4, 1'b0, 4'd0, 1'b0, 4'd0, 64'd16, 1'b0));
    send_instr(mem_op(CMD_ADD, 4'd3, 4'd4, 1'b1, 4'd0, 1'b0, 4'd15, 64'd1, 1'b1));
    send_instr(mem_op(CMD_ADD, 4'd5, 4'd15, 1'b1, 4'd2, 1'b1, 4'd0, '1, 1'b1));
    send_instr(mem_op(CMD_MOVE, 4'd6, 4'd1, 1'b1, 4'd0, 1'b1, 4'd8, 64'd2048, 1'b1));
    send_instr(reg_op(CMD_ADD, 4'd6, src_e'(2'd3), 4'd15, '1));
    send_instr(reg_op(CMD_MOVE, 4'd7, SRC_REG, 4'd15, '0));
    send_instr(reg_op(CMD_ADD, 4'd15, SRC_REG, 4'd15, '0));
    send_instr(reg_op(CMD_POP, 4'd8, SRC_REG, 4'd0, '0));
    send_instr(reg_op(CMD_POP, 4'd9, SRC_REG, 4'd0, '0));
    send_instr(reg_op(CMD_POP, 4'd4, SRC_REG, 4'd0, '0));
    send_instr(reg_op(CMD_DEC, 4'd4, SRC_REG, 4'd0, '0));
    send_instr(reg_op(CMD_INC, 4'd4, SRC_REG, 4'd0, '0));
    send_instr(reg_op(cmd_e'(3'd6), 4'd9, SRC_IMM, 4'd0, '1));
    send_instr(reg_op(cmd_e'(3'd7), 4'd15, SRC_MEM, 4'd0, '0));
    send_instr(in_t'({4'b0, {(IN_W - 4){1'b1}}}));
    send_instr(mem_op(CMD_ADD, 4'd15, 4'd15, 1'b1, 4'd15, 1'b1, 4'd15, '1, 1'b1));

    send_random(FirstTarget);
    for (int p = 0; p < 6; p++) begin
      s_axis_tvalid <= 1'b0;
      wait_drain();
      write_stack_top(tops[p]);
      steady = (p == 1 || p == 2);
      if (p == 2) hold_req = 1'b1;
      send_random(FirstTarget + PhaseItems * (p + 1));
      steady = 1'b0;
    end

    s_axis_tvalid <= 1'b0;
    wait_drain();
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d instructions and %0d checked results", sent, checked);
    $display("over %0d stack top writes plus the reset value", cfg_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/mxrse_pkg.sv
rtl/core/mxrse_regfile.sv
rtl/core/mxrse_stack.sv
rtl/core/mxrse_alu.sv
rtl/core/mini_x86_register_stack_executor_top.sv
rtl/core/mxrse_checker.sv
test/mini_x86_register_stack_executor_checker.sv
test/mini_x86_register_stack_executor_top_tb.sv
